// ===== rtl/core/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// shared types, codes and helpers of the sentence checker
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] MIN_LENGTH  = 8'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic {
    REG_MAX_LEN    = 1'b0,
    REG_TICK_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_BODY   = 5'b00001,
    PH_HI     = 5'b00010,
    PH_LO     = 5'b00100,
    PH_END    = 5'b01000,
    PH_BADFMT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] computed_checksum;
    logic [7:0] rx_checksum;
    logic [7:0] sentence_length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/nsc_parse.sv =====
// ----------------------------------------------------------------------------
// nsc_parse
// sentence parser state, checksum accumulation and tick window
// ----------------------------------------------------------------------------
module nsc_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             cmd,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       max_len,
  input  logic [15:0]      tick_limit,
  output logic             res_vld,
  output nsc_pkg::result_t res
);
  import nsc_pkg::*;

  logic        started_r, started_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  xor_r, xor_nxt;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  got_r, got_nxt;
  logic        trunc_r, trunc_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  logic [15:0] tmo;
  logic [15:0] ticks_inc;
  logic [7:0]  limit;
  hex_t        hx;
  logic        emit;

  assign tmo       = (tick_limit == 16'd0) ? 16'd1 : tick_limit;
  assign ticks_inc = (ticks_r == 16'hffff) ? ticks_r : ticks_r + 16'd1;
  assign limit     = ((max_len < MIN_LENGTH) ? MIN_LENGTH : max_len) - 8'd1;
  assign hx        = hex_decode(rx_byte);

  always_comb begin
    started_nxt = started_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    got_nxt     = got_r;
    trunc_nxt   = trunc_r;
    ticks_nxt   = ticks_r;
    emit        = 1'b0;
    res         = '0;
    if (cmd == CMD_TICK) begin
      ticks_nxt = ticks_inc;
      if (ticks_inc >= tmo) begin
        emit       = 1'b1;
        res.status = ST_TIMEOUT;
      end
    end else if (rx_byte == CHAR_DOLLAR) begin
      started_nxt = 1'b1;
      count_nxt   = 8'd1;
      xor_nxt     = '0;
      phase_nxt   = PH_BODY;
      hi_nxt      = '0;
      got_nxt     = '0;
      trunc_nxt   = 1'b0;
    end else if (started_r && rx_byte != CHAR_CR) begin
      if (rx_byte == CHAR_LF) begin
        emit                  = 1'b1;
        res.status            = (phase_r != PH_END) ? ST_BAD :
                                (xor_r == got_r) ? ST_OK : ST_MISMATCH;
        res.computed_checksum = xor_r;
        res.rx_checksum       = got_r;
        res.sentence_length   = count_r;
      end else if (count_r >= limit) begin
        emit                = 1'b1;
        res.status          = ST_OVERFLOW;
        res.sentence_length = count_r;
      end else begin
        count_nxt = count_r + 8'd1;
        if (!trunc_r && phase_r != PH_BADFMT) begin
          if (rx_byte == CHAR_NUL) begin
            if (phase_r == PH_END) trunc_nxt = 1'b1;
            else phase_nxt = PH_BADFMT;
          end else begin
            unique case (phase_r)
              PH_BODY: begin
                if (rx_byte == CHAR_STAR) phase_nxt = PH_HI;
                else xor_nxt = xor_r ^ rx_byte;
              end
              PH_HI: begin
                if (hx.ok) begin
                  hi_nxt    = hx.value;
                  phase_nxt = PH_LO;
                end else begin
                  phase_nxt = PH_BADFMT;
                end
              end
              PH_LO: begin
                if (hx.ok) begin
                  got_nxt   = {hi_r, hx.value};
                  phase_nxt = PH_END;
                end else begin
                  phase_nxt = PH_BADFMT;
                end
              end
              default: phase_nxt = PH_BADFMT;
            endcase
          end
        end
      end
    end
    if (emit) begin
      started_nxt = 1'b0;
      count_nxt   = '0;
      xor_nxt     = '0;
      phase_nxt   = PH_BODY;
      hi_nxt      = '0;
      got_nxt     = '0;
      trunc_nxt   = 1'b0;
      ticks_nxt   = '0;
    end
  end

  assign res_vld = acc & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      count_r   <= '0;
      xor_r     <= '0;
      phase_r   <= PH_BODY;
      hi_r      <= '0;
      got_r     <= '0;
      trunc_r   <= 1'b0;
      ticks_r   <= '0;
    end else if (acc) begin
      started_r <= started_nxt;
      count_r   <= count_nxt;
      xor_r     <= xor_nxt;
      phase_r   <= phase_nxt;
      hi_r      <= hi_nxt;
      got_r     <= got_nxt;
      trunc_r   <= trunc_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

// ===== rtl/core/nmea_sentence_checker_core.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// streaming nmea 0183 sentence checksum checker
// ----------------------------------------------------------------------------
// Each input beat (a received byte or a millisecond tick) is accepted and
// updates the parser state in a single pass; a beat that ends a sentence,
// overflows it or closes the tick window writes its result into the output
// register at the same edge that accepts it, or into the second entry when
// the output is stalled. A two-entry output buffer lets input beats keep
// flowing while one result waits; in_stall rises only when both entries are
// full. Configuration writes are taken in any cycle.
module nmea_sentence_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_rx_checksum,
  output logic [7:0]  out_sentence_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import nsc_pkg::*;

  logic [7:0]  max_len_r;
  logic [15:0] tmo_r;
  logic        acc;
  logic        res_vld;
  result_t     res;
  logic        out_vld_r, skid_vld_r;
  result_t     out_r, skid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign acc       = in_valid & ~skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 8'd83;
      tmo_r     <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_LEN:    max_len_r <= cfg_data[7:0];
        REG_TICK_LIMIT: tmo_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  nsc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .cmd        (in_cmd),
    .rx_byte    (in_rx_byte),
    .max_len    (max_len_r),
    .tick_limit (tmo_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r  <= skid_vld_r | res_vld;
      skid_vld_r <= 1'b0;
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_status            = out_r.status;
  assign out_computed_checksum = out_r.computed_checksum;
  assign out_rx_checksum       = out_r.rx_checksum;
  assign out_sentence_length   = out_r.sentence_length;

endmodule
